@@ design/rcz_pkg.sv @@
// rcz_pkg: shared types, constants and register codes of the 3x3 RGB filter.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package rcz_pkg;

   // Default sizes, handed to the top level parameters
   localparam int DEF_MAX_LINE_PIXELS    = 1024;
   localparam int DEF_COEF_FRACTION_BITS = 8;

   // Field and datapath widths
   localparam int PIX_W      = 8;                  // one color component
   localparam int PIXEL_W    = 3 * PIX_W;          // packed RGB, red in low bits
   localparam int COORD_W    = 10;                 // output coordinates
   localparam int DIM_W      = 11;                 // width / height registers
   localparam int COEF_W     = 16;                 // one signed coefficient
   localparam int TAPS       = 3;                  // kernel side
   localparam int NTAPS      = TAPS * TAPS;
   localparam int KROW_W     = TAPS * COEF_W;      // one kernel row register
   localparam int PROD_W     = COEF_W + PIX_W + 1; // signed coef x unsigned pixel
   localparam int SUM_W      = PROD_W + 4;         // nine products, no overflow
   localparam int CSR_IDX_W  = 3;
   localparam int COORD_CAP  = 1024;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   // Register reset values
   localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
   localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 11'd480;
   localparam logic [KROW_W-1:0] RST_KERNEL_TOP   = 48'd0;
   localparam logic [KROW_W-1:0] RST_KERNEL_MID   = 48'd256;
   localparam logic [KROW_W-1:0] RST_KERNEL_BOT   = 48'd0;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_KERNEL_TOP    = 3'd2,
      CSR_KERNEL_MIDDLE = 3'd3,
      CSR_KERNEL_BOTTOM = 3'd4
   } csr_index_type;

   // Input operation codes
   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } operation_type;

   // Request transaction payload
   typedef struct packed {
      operation_type    operation;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } req_payload_type;

   // Response transaction payload
   typedef struct packed {
      logic [PIX_W-1:0]   red_out;
      logic [PIX_W-1:0]   green_out;
      logic [PIX_W-1:0]   blue_out;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               frame_end;
   } rsp_payload_type;

   // Effective configuration; kernel[0] is the top row
   typedef struct packed {
      logic [DIM_W-1:0]             width;
      logic [DIM_W-1:0]             height;
      logic [TAPS-1:0][KROW_W-1:0]  kernel;
   } cfg_type;

   // Per-transaction control computed at accept time
   typedef struct packed {
      logic               has_result;
      logic               frame_end;
      logic [NTAPS-1:0]   use_tap;     // tap r*3+c lies inside the image
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } seq_ctrl_type;

endpackage

`default_nettype wire

@@ design/rcz_stream_if.sv @@
// rcz_req_if / rcz_rsp_if: valid-ready channels of the 3x3 RGB filter.
// Depends on rcz_pkg for the payload structs.
`default_nettype none

interface rcz_req_if;
   logic                     valid;
   logic                     ready;
   rcz_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rcz_rsp_if;
   logic                     valid;
   logic                     ready;
   rcz_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/rcz_csr.sv @@
// rcz_csr: configuration registers and clamping of width and height.
// Depends on rcz_pkg.
`default_nettype none

module rcz_csr #(
   parameter int MAX_LINE_PIXELS = rcz_pkg::DEF_MAX_LINE_PIXELS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [rcz_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rcz_pkg::KROW_W-1:0]       csr_wr_data,
   output rcz_pkg::cfg_type                      cfg
);

   localparam int WIDTH_CAP = (MAX_LINE_PIXELS < rcz_pkg::COORD_CAP) ?
                              MAX_LINE_PIXELS : rcz_pkg::COORD_CAP;

   logic [rcz_pkg::DIM_W-1:0]                      width_ff;
   logic [rcz_pkg::DIM_W-1:0]                      height_ff;
   logic [rcz_pkg::TAPS-1:0][rcz_pkg::KROW_W-1:0]  kernel_ff;

   // Register writes; unlisted indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rcz_pkg::RST_IMAGE_WIDTH;
         height_ff    <= rcz_pkg::RST_IMAGE_HEIGHT;
         kernel_ff[0] <= rcz_pkg::RST_KERNEL_TOP;
         kernel_ff[1] <= rcz_pkg::RST_KERNEL_MID;
         kernel_ff[2] <= rcz_pkg::RST_KERNEL_BOT;
      end else if (csr_wr_en) begin
         case (rcz_pkg::csr_index_type'(csr_index))
            rcz_pkg::CSR_IMAGE_WIDTH:   width_ff     <= csr_wr_data[rcz_pkg::DIM_W-1:0];
            rcz_pkg::CSR_IMAGE_HEIGHT:  height_ff    <= csr_wr_data[rcz_pkg::DIM_W-1:0];
            rcz_pkg::CSR_KERNEL_TOP:    kernel_ff[0] <= csr_wr_data;
            rcz_pkg::CSR_KERNEL_MIDDLE: kernel_ff[1] <= csr_wr_data;
            rcz_pkg::CSR_KERNEL_BOTTOM: kernel_ff[2] <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Effective sizes: at least one, at most the line store and coordinate range
   always_comb begin
      cfg.kernel = kernel_ff;
      if (width_ff == '0) begin
         cfg.width = rcz_pkg::DIM_W'(1);
      end else if (width_ff > rcz_pkg::DIM_W'(WIDTH_CAP)) begin
         cfg.width = rcz_pkg::DIM_W'(WIDTH_CAP);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff == '0) begin
         cfg.height = rcz_pkg::DIM_W'(1);
      end else if (height_ff > rcz_pkg::DIM_W'(rcz_pkg::COORD_CAP)) begin
         cfg.height = rcz_pkg::DIM_W'(rcz_pkg::COORD_CAP);
      end else begin
         cfg.height = height_ff;
      end
   end

endmodule

`default_nettype wire

@@ design/rcz_seq.sv @@
// rcz_seq: input and output raster counters, edge masks and frame end.
// Depends on rcz_pkg; feeds the line store address and the per-item control.
`default_nettype none

module rcz_seq #(
   parameter int MAX_LINE_PIXELS = rcz_pkg::DEF_MAX_LINE_PIXELS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 accept,
   input  rcz_pkg::cfg_type                          cfg,
   output rcz_pkg::seq_ctrl_type                     ctrl,
   output logic [$clog2(MAX_LINE_PIXELS)-1:0]        rd_idx
);

   localparam int IDX_W = $clog2(MAX_LINE_PIXELS);

   logic [rcz_pkg::COORD_W-1:0] in_col_ff,  in_col_in;
   logic [rcz_pkg::DIM_W-1:0]   in_row_ff,  in_row_in;
   logic [rcz_pkg::COORD_W-1:0] out_col_ff, out_col_in;
   logic [rcz_pkg::COORD_W-1:0] out_row_ff, out_row_in;

   logic [rcz_pkg::DIM_W-1:0]   in_col_p1, out_col_p1, out_row_p1;
   logic                        in_wrap, last_col, last_row;
   logic [rcz_pkg::TAPS-1:0]    row_ok, col_ok;

   // Current column indexes the line store; it always stays below the depth
   assign rd_idx = IDX_W'(in_col_ff);

   // Window readiness, edge masks and frame end for the item at the port
   always_comb begin
      in_col_p1  = rcz_pkg::DIM_W'(in_col_ff) + rcz_pkg::DIM_W'(1);
      out_col_p1 = rcz_pkg::DIM_W'(out_col_ff) + rcz_pkg::DIM_W'(1);
      out_row_p1 = rcz_pkg::DIM_W'(out_row_ff) + rcz_pkg::DIM_W'(1);
      in_wrap    = in_col_p1 >= cfg.width;
      last_col   = out_col_p1 >= cfg.width;
      last_row   = out_row_p1 >= cfg.height;

      row_ok = {!last_row, 1'b1, out_row_ff != '0};
      col_ok = {!last_col, 1'b1, out_col_ff != '0};

      ctrl.has_result = (in_row_ff >= rcz_pkg::DIM_W'(2)) ||
                        ((in_row_ff == rcz_pkg::DIM_W'(1)) && (in_col_ff != '0));
      ctrl.frame_end  = ctrl.has_result && last_col && last_row;
      ctrl.column     = out_col_ff;
      ctrl.row        = out_row_ff;
      for (int r = 0; r < rcz_pkg::TAPS; r++) begin
         for (int c = 0; c < rcz_pkg::TAPS; c++) begin
            ctrl.use_tap[r*rcz_pkg::TAPS + c] = row_ok[r] && col_ok[c];
         end
      end
   end

   // Counter next values
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         if (in_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + rcz_pkg::DIM_W'(1);
         end else begin
            in_col_in = in_col_p1[rcz_pkg::COORD_W-1:0];
         end
         if (ctrl.has_result) begin
            if (last_col) begin
               out_col_in = '0;
               out_row_in = out_row_ff + rcz_pkg::COORD_W'(1);
            end else begin
               out_col_in = out_col_p1[rcz_pkg::COORD_W-1:0];
            end
         end
         if (ctrl.frame_end) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

`ifndef ASSERT_OFF
   // Line store address never leaves the store
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(in_col_ff) < MAX_LINE_PIXELS)
      else $error("input column beyond line store depth");

   // Frame end returns every counter to the frame origin
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && ctrl.frame_end |=>
         in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0)
      else $error("counters not cleared after frame end");
`endif

endmodule

`default_nettype wire

@@ design/rcz_line_buf.sv @@
// rcz_line_buf: the two line stores in one memory word, with read forwarding.
// Depends on rcz_pkg. Read at accept, write when the item leaves the input stage.
`default_nettype none

module rcz_line_buf #(
   parameter int MAX_LINE_PIXELS = rcz_pkg::DEF_MAX_LINE_PIXELS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 rd_en,
   input  wire logic [$clog2(MAX_LINE_PIXELS)-1:0]   rd_idx,
   input  wire logic [rcz_pkg::PIXEL_W-1:0]          pix_in,
   input  wire logic                                 wr_en,
   output logic [rcz_pkg::PIXEL_W-1:0]               top,
   output logic [rcz_pkg::PIXEL_W-1:0]               mid,
   output logic [rcz_pkg::PIXEL_W-1:0]               pix
);

   localparam int IDX_W  = $clog2(MAX_LINE_PIXELS);
   localparam int WORD_W = 2 * rcz_pkg::PIXEL_W;   // {upper, middle}

   logic [WORD_W-1:0]               line_mem [MAX_LINE_PIXELS];
   logic [WORD_W-1:0]               rd_q_ff;
   logic [WORD_W-1:0]               fwd_data_ff;
   logic                            fwd_ff;
   logic [IDX_W-1:0]                idx_ff;
   logic [rcz_pkg::PIXEL_W-1:0]     pix_ff;
   logic [WORD_W-1:0]               rd_word, wr_word;

   // Upper line takes the old middle entry, middle line the new pixel
   assign rd_word = fwd_ff ? fwd_data_ff : rd_q_ff;
   assign top     = rd_word[WORD_W-1:rcz_pkg::PIXEL_W];
   assign mid     = rd_word[rcz_pkg::PIXEL_W-1:0];
   assign pix     = pix_ff;
   assign wr_word = {mid, pix_ff};

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[idx_ff] <= wr_word;
      end
      if (rd_en) begin
         rd_q_ff <= line_mem[rd_idx];
      end
   end

   // Item payload; forward the word written this cycle to the same address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         idx_ff      <= rd_idx;
         pix_ff      <= pix_in;
         fwd_data_ff <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (rd_idx == idx_ff);
      end
   end

endmodule

`default_nettype wire

@@ design/rcz_filter.sv @@
// rcz_filter: 3x3 window, masked products, sums, clamp and result register.
// Depends on rcz_pkg and rcz_rsp_if; runs the two back stages of the pipeline.
`default_nettype none

module rcz_filter #(
   parameter int COEF_FRACTION_BITS = rcz_pkg::DEF_COEF_FRACTION_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         s1_valid,
   input  rcz_pkg::seq_ctrl_type             s1_ctrl,
   input  wire logic [rcz_pkg::PIXEL_W-1:0]  top,
   input  wire logic [rcz_pkg::PIXEL_W-1:0]  mid,
   input  wire logic [rcz_pkg::PIXEL_W-1:0]  pix,
   input  rcz_pkg::cfg_type                  cfg,
   output logic                              s1_move,
   output logic                              s2_free,
   rcz_rsp_if.source                         rsp_if
);

   typedef logic [rcz_pkg::TAPS-1:0][rcz_pkg::TAPS-1:0][rcz_pkg::PIXEL_W-1:0] window_type;
   typedef logic [2:0][rcz_pkg::NTAPS-1:0][rcz_pkg::PROD_W-1:0] prod_type;

   window_type                  window_ff, win_nx;
   prod_type                    prod_ff, prod_in;
   logic                        s2_valid_ff, s2_valid_in;
   rcz_pkg::seq_ctrl_type       s2_ctrl_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   rcz_pkg::rsp_payload_type    rsp_ff, rsp_in;
   logic                        out_free;
   logic [2:0][rcz_pkg::PIX_W-1:0] chan_out;

   function automatic logic signed [rcz_pkg::SUM_W-1:0] sext(
      input logic [rcz_pkg::PROD_W-1:0] p);
      sext = {{(rcz_pkg::SUM_W - rcz_pkg::PROD_W){p[rcz_pkg::PROD_W-1]}}, p};
   endfunction

   // Stage handshake
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_move   = s1_valid && s2_free;

   // Window after sliding one column in
   always_comb begin
      for (int r = 0; r < rcz_pkg::TAPS; r++) begin
         win_nx[r][0] = window_ff[r][1];
         win_nx[r][1] = window_ff[r][2];
      end
      win_nx[0][2] = top;
      win_nx[1][2] = mid;
      win_nx[2][2] = pix;
   end

   // Masked products, one per tap and channel
   always_comb begin
      logic signed [rcz_pkg::COEF_W-1:0] cf;
      logic signed [rcz_pkg::PIX_W:0]    pv;
      logic signed [rcz_pkg::PROD_W-1:0] pr;
      prod_in = '0;
      for (int r = 0; r < rcz_pkg::TAPS; r++) begin
         for (int c = 0; c < rcz_pkg::TAPS; c++) begin
            for (int ch = 0; ch < 3; ch++) begin
               cf = cfg.kernel[r][c*rcz_pkg::COEF_W +: rcz_pkg::COEF_W];
               pv = {1'b0, win_nx[r][c][ch*rcz_pkg::PIX_W +: rcz_pkg::PIX_W]};
               pr = cf * pv;
               if (s1_ctrl.use_tap[r*rcz_pkg::TAPS + c]) begin
                  prod_in[ch][r*rcz_pkg::TAPS + c] = pr;
               end
            end
         end
      end
   end

   // Window state; cleared after the last pixel of a frame
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_move) begin
         window_ff <= s1_ctrl.frame_end ? '0 : win_nx;
      end
   end

   // Product stage
   assign s2_valid_in = s2_free ? (s1_move && s1_ctrl.has_result) : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         prod_ff    <= prod_in;
         s2_ctrl_ff <= s1_ctrl;
      end
   end

   // Sum tree, truncation and clamp to 0..255
   always_comb begin
      logic signed [rcz_pkg::SUM_W-1:0] sum;
      logic [rcz_pkg::SUM_W-1:0]        q;
      for (int ch = 0; ch < 3; ch++) begin
         sum = ((sext(prod_ff[ch][0]) + sext(prod_ff[ch][1])) +
                (sext(prod_ff[ch][2]) + sext(prod_ff[ch][3]))) +
               ((sext(prod_ff[ch][4]) + sext(prod_ff[ch][5])) +
                (sext(prod_ff[ch][6]) + sext(prod_ff[ch][7]))) +
               sext(prod_ff[ch][8]);
         q = rcz_pkg::SUM_W'(sum) >> COEF_FRACTION_BITS;
         if (sum[rcz_pkg::SUM_W-1]) begin
            chan_out[ch] = '0;
         end else if (q > rcz_pkg::SUM_W'(rcz_pkg::PIX_MAX)) begin
            chan_out[ch] = rcz_pkg::PIX_MAX;
         end else begin
            chan_out[ch] = q[rcz_pkg::PIX_W-1:0];
         end
      end
      rsp_in.red_out   = chan_out[0];
      rsp_in.green_out = chan_out[1];
      rsp_in.blue_out  = chan_out[2];
      rsp_in.column    = s2_ctrl_ff.column;
      rsp_in.row       = s2_ctrl_ff.row;
      rsp_in.frame_end = s2_ctrl_ff.frame_end;
   end

   // Result register
   assign rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

`ifndef ASSERT_OFF
   // Frame end leaves a zero window for the next frame
   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_ctrl.frame_end |=> window_ff == '0)
      else $error("window not cleared after frame end");

   // A blocked product stage keeps its transaction
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_free |=> s2_valid_ff && $stable(s2_ctrl_ff))
      else $error("product stage lost a transaction under stall");
`endif

endmodule

`default_nettype wire

@@ design/rgb_conv3x3_zero_pad.sv @@
// rgb_conv3x3_zero_pad: top level of the zero-padded 3x3 RGB convolution filter.
// Depends on rcz_pkg, rcz_stream_if, rcz_csr, rcz_seq, rcz_line_buf, rcz_filter.
//
//   channel  direction  handshake       payload
//   req_if   in         valid / ready   operation, red, green, blue
//   rsp_if   out        valid / ready   red_out, green_out, blue_out, column, row, frame_end
//   csr_*    in         csr_wr_en       csr_index (3b), csr_wr_data (48b), write only
//
// One transaction per clock while rsp_if keeps ready; from accept to result valid an item
// passes the input stage with line store read, the product stage and the result register.
// The line store memory port is read at accept and written as the item leaves
// the input stage, with a bypass for back-to-back hits on one address.
// A result is produced width+1 transactions after its pixel. Synchronous reset
// clears counters, window and valids; the line store needs no clearing pass.
// Response stalls back up stage by stage; bubbles are filled while a result waits.
`default_nettype none

module rgb_conv3x3_zero_pad #(
   parameter int MAX_LINE_PIXELS    = rcz_pkg::DEF_MAX_LINE_PIXELS,
   parameter int COEF_FRACTION_BITS = rcz_pkg::DEF_COEF_FRACTION_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rcz_req_if.sink                             req_if,
   rcz_rsp_if.source                           rsp_if,
   input  wire logic                           csr_wr_en,
   input  wire logic [rcz_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rcz_pkg::KROW_W-1:0]     csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_LINE_PIXELS);

   rcz_pkg::cfg_type             cfg;
   rcz_pkg::seq_ctrl_type        ctrl;
   rcz_pkg::seq_ctrl_type        s1_ctrl_ff;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_move, s2_free, s1_free, accept;
   logic [IDX_W-1:0]             rd_idx;
   logic [rcz_pkg::PIXEL_W-1:0]  pix_in, top, mid, pix;

   // Input handshake
   assign s1_free      = !s1_valid_ff || s2_free;
   assign req_if.ready = s1_free;
   assign accept       = req_if.valid && s1_free;

   // A flush transaction enters as a black pixel
   assign pix_in = (req_if.payload.operation == rcz_pkg::OP_FLUSH) ? '0 :
                   {req_if.payload.blue, req_if.payload.green, req_if.payload.red};

   rcz_csr #(.MAX_LINE_PIXELS(MAX_LINE_PIXELS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   rcz_seq #(.MAX_LINE_PIXELS(MAX_LINE_PIXELS)) u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cfg    (cfg),
      .ctrl   (ctrl),
      .rd_idx (rd_idx)
   );

   rcz_line_buf #(.MAX_LINE_PIXELS(MAX_LINE_PIXELS)) u_line_buf (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .rd_idx (rd_idx),
      .pix_in (pix_in),
      .wr_en  (s1_move),
      .top    (top),
      .mid    (mid),
      .pix    (pix)
   );

   // Input stage control register
   assign s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= ctrl;
      end
   end

   rcz_filter #(.COEF_FRACTION_BITS(COEF_FRACTION_BITS)) u_filter (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid_ff),
      .s1_ctrl  (s1_ctrl_ff),
      .top      (top),
      .mid      (mid),
      .pix      (pix),
      .cfg      (cfg),
      .s1_move  (s1_move),
      .s2_free  (s2_free),
      .rsp_if   (rsp_if)
   );

`ifndef ASSERT_OFF
   // A stalled input stage keeps its transaction and control
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_ctrl_ff))
      else $error("input stage lost a transaction under stall");
`endif

endmodule

`default_nettype wire
